// ===== sv/lsa_pkg.sv =====
`default_nettype none
package lsa_pkg;
   localparam logic [2:0] ST_ASSIGNED = 3'd0;
   localparam logic [2:0] ST_WAIT     = 3'd1;
   localparam logic [2:0] ST_ERROR    = 3'd2;
   localparam logic [2:0] ST_RELEASED = 3'd3;
   localparam logic [2:0] ST_REJECTED = 3'd4;
   localparam logic       OP_REQUEST  = 1'b0;
   localparam logic       OP_TICK     = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [9:0] requester_tag;
      logic [7:0] lease_units;
   } item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] requester_tag_res;
      logic [3:0] slot_index;
      logic       last;
   } result_type;
endpackage
`default_nettype wire

// ===== sv/lsa_ram.sv =====
`default_nettype none
module lsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/lsa_front.sv =====
`default_nettype none
module lsa_front
   import lsa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          q_valid,
   input  wire logic     q_ready,
   output item_type      q_item
);
   item_type   buf_ff [2];
   logic [1:0] cnt_ff;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_item   = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
      end
      if (push) buf_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ===== sv/lsa_back.sv =====
`default_nettype none
module lsa_back
   import lsa_pkg::*;
#(
   parameter int SLOTS       = 10,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] tpu,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  wire item_type    q_item,
   output logic             out_valid,
   input  wire logic        out_ready,
   output result_type       out_res
);
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_REQ, S_SCAN, S_QRD, S_QMUL, S_QASN
   } state_type;

   state_type   state_ff;
   logic [SLOTS-1:0] busy_ff, exp_ff;
   logic [9:0]  owner_ff [SLOTS];
   logic [23:0] rem_ff [SLOTS];
   logic [QW-1:0] head_ff, tail_ff;
   logic [QW:0]   count_ff;
   item_type    cur_ff;
   logic [23:0] ticks_ff;
   logic [SW-1:0] scan_ff;
   logic        ovalid_ff, pend_ff;
   result_type  ores_ff, pres_ff;

   logic        wq_en;
   logic [17:0] q_rd;
   logic [SW-1:0] free_idx;
   logic        free_any;
   logic [SW-1:0] exp_idx;
   logic        exp_any, exp_more;
   logic        slot_out;
   logic [SLOTS-1:0] exp_now;

   lsa_ram #(.WIDTH(18), .DEPTH(QUEUE_DEPTH)) u_wait (
      .clock  (clock),
      .wr_en  (wq_en),
      .wr_addr(tail_ff),
      .wr_data({cur_ff.requester_tag, cur_ff.lease_units}),
      .rd_addr(head_ff),
      .rd_data(q_rd)
   );

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_any = 1'b1;
            free_idx = SW'(i);
         end
      end
      exp_any = 1'b0;
      exp_idx = '0;
      exp_more = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (exp_ff[i]) begin
            exp_more = exp_any;
            exp_any  = 1'b1;
            exp_idx  = SW'(i);
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         exp_now[i] = busy_ff[i] && (rem_ff[i] <= 24'd1);
      end
   end

   assign slot_out = ovalid_ff && !out_ready;
   assign q_ready  = (state_ff == S_IDLE) && !pend_ff;
   assign out_valid = ovalid_ff;
   assign out_res   = ores_ff;
   assign wq_en = (state_ff == S_REQ) && !free_any && (count_ff != (QW+1)'(QUEUE_DEPTH))
                  && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= '0;
         exp_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         if (pend_ff && !slot_out) begin
            ores_ff   <= pres_ff;
            ovalid_ff <= 1'b1;
            pend_ff   <= 1'b0;
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid && q_ready) begin
                  cur_ff <= q_item;
                  if (q_item.operation == OP_TICK) begin
                     for (int i = 0; i < SLOTS; i++) begin
                        if (busy_ff[i] && rem_ff[i] != 24'd0) rem_ff[i] <= rem_ff[i] - 24'd1;
                     end
                     exp_ff   <= exp_now;
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               ticks_ff <= 24'(cur_ff.lease_units) * 24'(tpu);
               state_ff <= S_REQ;
            end
            S_REQ: begin
               if (!pend_ff) begin
                  pend_ff <= 1'b1;
                  pres_ff.requester_tag_res <= cur_ff.requester_tag;
                  pres_ff.last <= 1'b1;
                  pres_ff.slot_index <= '0;
                  if (cur_ff.lease_units == 8'd0) begin
                     pres_ff.status <= ST_ERROR;
                  end else if (free_any) begin
                     pres_ff.status     <= ST_ASSIGNED;
                     pres_ff.slot_index <= 4'(free_idx);
                     busy_ff[free_idx]  <= 1'b1;
                     owner_ff[free_idx] <= cur_ff.requester_tag;
                     rem_ff[free_idx]   <= ticks_ff;
                  end else if (wq_en) begin
                     pres_ff.status <= ST_WAIT;
                     tail_ff  <= (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     pres_ff.status <= ST_REJECTED;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_SCAN: begin
               if (!exp_any) begin
                  state_ff <= S_IDLE;
               end else if (!pend_ff) begin
                  pend_ff <= 1'b1;
                  pres_ff.status <= ST_RELEASED;
                  pres_ff.requester_tag_res <= owner_ff[exp_idx];
                  pres_ff.slot_index <= 4'(exp_idx);
                  pres_ff.last <= !exp_more && (count_ff == '0);
                  busy_ff[exp_idx] <= 1'b0;
                  exp_ff[exp_idx]  <= 1'b0;
                  scan_ff <= exp_idx;
                  if (count_ff != '0) begin
                     state_ff <= S_QRD;
                  end else if (!exp_more) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_QRD: state_ff <= S_QMUL;
            S_QMUL: begin
               ticks_ff <= 24'(q_rd[7:0]) * 24'(tpu);
               state_ff <= S_QASN;
            end
            S_QASN: begin
               if (!pend_ff) begin
                  pend_ff <= 1'b1;
                  pres_ff.status <= ST_ASSIGNED;
                  pres_ff.requester_tag_res <= q_rd[17:8];
                  pres_ff.slot_index <= 4'(scan_ff);
                  pres_ff.last <= !exp_any;
                  busy_ff[scan_ff]  <= 1'b1;
                  owner_ff[scan_ff] <= q_rd[17:8];
                  rem_ff[scan_ff]   <= ticks_ff;
                  head_ff  <= (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= exp_any ? S_SCAN : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== sv/lease_slot_allocator_with_waitlist.sv =====
// channel | ports      | payload
// request | req_t*     | tuser: operation; tdata: requester_tag, lease_units
// result  | rsp_t*     | tuser: status; tdata: requester_tag_res, slot_index; tlast: last
// config  | csr_*      | ticks_per_unit
// A request runs the multiply and request states, then its result is registered.
// A tick scans and returns to idle if nothing expires; each release takes a scan
// step, and each reassignment from the queue the read, multiply and assign states.
// Reset is synchronous; the 2-entry front queue accepts while the back part works.
// A stalled result holds the back part in place.
`default_nettype none
module lease_slot_allocator_with_waitlist
   import lsa_pkg::*;
#(
   parameter int SLOTS       = 10,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,  // operation
   input  wire logic [23:0] req_tdata,  // requester_tag, lease_units, pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       rsp_tuser,  // status
   output logic [15:0]      rsp_tdata,  // requester_tag_res, slot_index, pad
   output logic             rsp_tlast
);
   logic [15:0] tpu_ff;
   item_type    in_item, q_item;
   logic        q_valid, q_ready;
   result_type  res;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff <= 16'd5;
      end else if (csr_we) begin
         tpu_ff <= csr_wdata;
      end
   end

   assign in_item.operation     = req_tuser;
   assign in_item.requester_tag = req_tdata[9:0];
   assign in_item.lease_units   = req_tdata[17:10];

   lsa_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item,
      .q_valid, .q_ready, .q_item
   );

   lsa_back #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .tpu(tpu_ff),
      .q_valid, .q_ready, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {2'd0, res.slot_index, res.requester_tag_res};
   assign rsp_tuser = res.status;
   assign rsp_tlast = res.last;
endmodule
`default_nettype wire
